@@ hw/rtl/nrsd_pkg.sv @@
// ----------------------------------------------------------------------------
// nrsd_pkg
// Shared types and codes for the 4-bit-per-pixel run-length sprite decoder.
// ----------------------------------------------------------------------------
package nrsd_pkg;

    // Decoder phase within a frame.
    typedef enum logic [2:0] {
        PH_WAIT = 3'd0,
        PH_HDR1 = 3'd1,
        PH_HDR2 = 3'd2,
        PH_HDR3 = 3'd3,
        PH_CTRL = 3'd4,
        PH_REP  = 3'd5,
        PH_LIT  = 3'd6
    } nrsd_phase_t;

    // Result status codes.
    localparam logic [1:0] STAT_HEADER       = 2'd0;
    localparam logic [1:0] STAT_RUN          = 2'd1;
    localparam logic [1:0] STAT_EMPTY        = 2'd2;
    localparam logic [1:0] STAT_UNCOMPRESSED = 2'd3;

    localparam int PIX_W = 23;

    // Architectural decoder state.
    typedef struct packed {
        nrsd_phase_t        phase;
        logic [14:0]        width_hold;
        logic [7:0]         height_hold;
        logic [7:0]         palette_offset;
        logic [PIX_W-1:0]   pixels_left;
        logic [6:0]         run_left;
        logic               compressed_flag;
    } nrsd_state_t;

    // One result item.
    typedef struct packed {
        logic [1:0]  status;
        logic [14:0] frame_width;
        logic [7:0]  frame_height;
        logic [7:0]  index_first;
        logic [7:0]  index_second;
        logic [6:0]  pair_count;
        logic        frame_done;
    } nrsd_result_t;

endpackage

@@ hw/rtl/nrsd_in_if.sv @@
// ----------------------------------------------------------------------------
// nrsd_in_if
// Byte stream channel into the sprite decoder.
// ----------------------------------------------------------------------------
interface nrsd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       frame_start;

    modport source (output valid, output data_byte, output frame_start, input ready);
    modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

@@ hw/rtl/nrsd_out_if.sv @@
// ----------------------------------------------------------------------------
// nrsd_out_if
// Result channel out of the sprite decoder.
// ----------------------------------------------------------------------------
interface nrsd_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [14:0] frame_width;
    logic [7:0]  frame_height;
    logic [7:0]  index_first;
    logic [7:0]  index_second;
    logic [6:0]  pair_count;
    logic        frame_done;

    modport source (output valid, output status, output frame_width, output frame_height,
                    output index_first, output index_second, output pair_count,
                    output frame_done, input ready);
    modport sink   (input valid, input status, input frame_width, input frame_height,
                    input index_first, input index_second, input pair_count,
                    input frame_done, output ready);
endinterface

@@ hw/rtl/nrsd_step.sv @@
// ----------------------------------------------------------------------------
// nrsd_step
// Combinational decode of one stream byte: next decoder state and result.
// ----------------------------------------------------------------------------
module nrsd_step (
    input  nrsd_pkg::nrsd_state_t  cur,
    input  logic [7:0]             data_byte,
    input  logic                   frame_start,
    output nrsd_pkg::nrsd_state_t  nxt,
    output nrsd_pkg::nrsd_result_t res,
    output logic                   res_valid
);
    import nrsd_pkg::*;

    logic             emit;
    logic [6:0]       emit_pairs;
    logic [PIX_W:0]   owed;
    logic [6:0]       rep_pairs;
    logic [PIX_W-1:0] take;
    logic [PIX_W-1:0] pix_after;
    logic [6:0]       lit_left;

    // Pairs still owed in the frame, and the repeat run clipped to it.
    assign owed      = ({1'b0, cur.pixels_left} + {{PIX_W{1'b0}}, 1'b1}) >> 1;
    assign rep_pairs = ({{(PIX_W-6){1'b0}}, cur.run_left} < owed) ? cur.run_left
                                                                   : owed[6:0];
    assign lit_left  = (cur.run_left != 7'd0) ? cur.run_left - 7'd1 : 7'd0;

    // Pixels remaining once the emitted pairs are taken off.
    assign take      = {{(PIX_W-8){1'b0}}, emit_pairs, 1'b0};
    assign pix_after = (take >= cur.pixels_left) ? '0 : cur.pixels_left - take;

    // Phase sequencing and header capture.
    always_comb
    begin
        nxt        = cur;
        res        = '0;
        res_valid  = 1'b0;
        emit       = 1'b0;
        emit_pairs = 7'd0;

        if (frame_start)
        begin
            nxt.width_hold  = {7'd0, data_byte};
            nxt.run_left    = 7'd0;
            nxt.pixels_left = '0;
            nxt.phase       = PH_HDR1;
        end
        else
        begin
            unique case (cur.phase)
                PH_HDR1:
                begin
                    nxt.width_hold      = {data_byte[6:0], cur.width_hold[7:0]};
                    nxt.compressed_flag = data_byte[7];
                    nxt.phase           = PH_HDR2;
                end
                PH_HDR2:
                begin
                    nxt.height_hold = data_byte;
                    nxt.pixels_left = {{(PIX_W-15){1'b0}}, cur.width_hold}
                                      * {{(PIX_W-8){1'b0}}, data_byte};
                    nxt.phase       = PH_HDR3;
                end
                PH_HDR3:
                begin
                    nxt.palette_offset = data_byte;
                    res_valid          = 1'b1;
                    res.frame_width    = cur.width_hold;
                    res.frame_height   = cur.height_hold;
                    priority if (cur.pixels_left == '0)
                    begin
                        res.status     = STAT_EMPTY;
                        res.frame_done = 1'b1;
                        nxt.phase      = PH_WAIT;
                    end
                    else if (!cur.compressed_flag)
                    begin
                        res.status      = STAT_UNCOMPRESSED;
                        res.frame_done  = 1'b1;
                        nxt.pixels_left = '0;
                        nxt.phase       = PH_WAIT;
                    end
                    else
                    begin
                        res.status = STAT_HEADER;
                        nxt.phase  = PH_CTRL;
                    end
                end
                PH_CTRL:
                begin
                    nxt.run_left = data_byte[6:0];
                    priority if (data_byte[7])
                        nxt.phase = PH_REP;
                    else if (data_byte[6:0] != 7'd0)
                        nxt.phase = PH_LIT;
                    else
                        nxt.phase = PH_CTRL;
                end
                PH_REP:
                begin
                    nxt.phase = PH_CTRL;
                    if (cur.run_left != 7'd0)
                    begin
                        nxt.run_left = 7'd0;
                        emit         = 1'b1;
                        emit_pairs   = rep_pairs;
                    end
                end
                PH_LIT:
                begin
                    nxt.run_left = lit_left;
                    if (lit_left == 7'd0)
                        nxt.phase = PH_CTRL;
                    emit       = 1'b1;
                    emit_pairs = 7'd1;
                end
                default:
                begin
                    nxt.phase = PH_WAIT;
                end
            endcase
        end

        // Pixel pair result; ends the frame once the total is reached.
        if (emit)
        begin
            res_valid        = 1'b1;
            res.status       = STAT_RUN;
            res.index_first  = {4'd0, data_byte[3:0]} + cur.palette_offset;
            res.index_second = {4'd0, data_byte[7:4]} + cur.palette_offset;
            res.pair_count   = emit_pairs;
            nxt.pixels_left  = pix_after;
            if (pix_after == '0)
            begin
                res.frame_done = 1'b1;
                nxt.phase      = PH_WAIT;
                nxt.run_left   = 7'd0;
            end
        end
    end

endmodule

@@ hw/rtl/nibble_rle_sprite_decoder_top.sv @@
// ----------------------------------------------------------------------------
// nibble_rle_sprite_decoder_top
// Decodes a 4bpp run-length sprite stream into header and pixel-run results.
// ----------------------------------------------------------------------------
// An accepted byte is first held in the input register; its result is then
// captured in the output register, from which the sink takes it.
// Throughput: 1 byte per cycle; the only stall is back-pressure from the sink.
// The input register and the result register form a two-stage pipeline that
// advances together whenever the result register is free or being drained.
// Reset: asynchronous, active low; clears both valid flags and the decoder
// state, leaving the block waiting for the first header byte of a frame.
module nibble_rle_sprite_decoder_top (
    input  logic clk,
    input  logic rst_n,
    nrsd_in_if.sink    stream,
    nrsd_out_if.source result
);
    import nrsd_pkg::*;

    logic          s1_valid_reg;
    logic [7:0]    s1_byte_reg;
    logic          s1_start_reg;
    nrsd_state_t   state_reg;
    nrsd_state_t   state_next;
    nrsd_result_t  step_res;
    logic          step_valid;
    logic          out_valid_reg;
    nrsd_result_t  out_data_reg;
    logic          advance;

    // Pipeline moves when the result register is empty or being taken.
    assign advance      = !out_valid_reg || result.ready;
    assign stream.ready = !s1_valid_reg || advance;

    // Decode logic for the byte held in the input register.
    nrsd_step u_step (
        .cur         (state_reg),
        .data_byte   (s1_byte_reg),
        .frame_start (s1_start_reg),
        .nxt         (state_next),
        .res         (step_res),
        .res_valid   (step_valid)
    );

    // Control registers: valid flags and decoder state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '{phase: PH_WAIT, default: '0};
        end
        else
        begin
            if (stream.ready)
                s1_valid_reg <= stream.valid;
            if (advance)
                out_valid_reg <= s1_valid_reg && step_valid;
            if (s1_valid_reg && advance)
                state_reg <= state_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (stream.valid && stream.ready)
        begin
            s1_byte_reg  <= stream.data_byte;
            s1_start_reg <= stream.frame_start;
        end
        if (advance && s1_valid_reg)
            out_data_reg <= step_res;
    end

    // Drive the result channel.
    assign result.valid        = out_valid_reg;
    assign result.status       = out_data_reg.status;
    assign result.frame_width  = out_data_reg.frame_width;
    assign result.frame_height = out_data_reg.frame_height;
    assign result.index_first  = out_data_reg.index_first;
    assign result.index_second = out_data_reg.index_second;
    assign result.pair_count   = out_data_reg.pair_count;
    assign result.frame_done   = out_data_reg.frame_done;

    // A pixel run always repeats its pair at least once.
    a_run_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.status == STAT_RUN) |-> (result.pair_count != 7'd0))
        else $error("pixel run with zero pair count");

    // Inside the pixel data of a frame some pixels are always still owed.
    a_pixels_owed: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.phase == PH_CTRL || state_reg.phase == PH_REP ||
         state_reg.phase == PH_LIT) |-> (state_reg.pixels_left != '0))
        else $error("pixel phase with no pixels left");

    // No run count survives into the waiting phase.
    a_wait_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.phase == PH_WAIT) |-> (state_reg.run_left == 7'd0))
        else $error("run count left over while waiting");

    // With the result register empty the input side is always open.
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> stream.ready)
        else $error("input stalled with empty result register");

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the 4-bit-per-pixel run-length sprite decoder.
// A cycle-free decoder model tracks every accepted stream byte and queues the
// header and pixel-run results it should cause. Each result transaction
// leaving the block is compared with the oldest queued result, field by field.
// Directed frames hit the header corner cases and the run rules, and random
// frames follow, with random gaps on the stream side and random back-pressure
// on the result side.
// ----------------------------------------------------------------------------
module tb;
    import nrsd_pkg::*;

    localparam int TARGET_BYTES = 2000;
    localparam int STALL_LIMIT  = 1000;
    localparam int MAX_REPORTS  = 10;

    logic clk;
    logic rst_n;

    nrsd_in_if  stream_if ();
    nrsd_out_if result_if ();

    nibble_rle_sprite_decoder_top u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (stream_if),
        .result (result_if)
    );

    // Decoder model state.
    nrsd_phase_t dec_phase;
    logic [14:0] dec_width;
    logic [7:0]  dec_height;
    logic [7:0]  dec_offset;
    logic [22:0] dec_pixels_left;
    logic [6:0]  dec_run_left;
    logic        dec_compressed;

    // Results the decoder still owes, oldest first.
    nrsd_result_t expected_results [$];

    int  errors;
    int  results_seen;
    int  runs_seen;
    int  bytes_sent;
    int  noise_bytes;
    int  frames_sent;
    bit  gaps_on;
    bit  stalls_on;
    int  stall_left;

    // Clock generation.
    always #6 clk = ~clk;

    // Put the decoder model back to its state after reset.
    function automatic void reset_decoder();
        dec_phase       = PH_WAIT;
        dec_width       = '0;
        dec_height      = '0;
        dec_offset      = '0;
        dec_pixels_left = '0;
        dec_run_left    = '0;
        dec_compressed  = 1'b0;
    endfunction

    // Build a pixel-run result and take its pixels off the frame total.
    function automatic nrsd_result_t emit_run(input logic [7:0] b, input logic [6:0] pairs);
        nrsd_result_t r;
        logic [7:0]   take;
        r              = '0;
        r.status       = STAT_RUN;
        r.index_first  = {4'h0, b[3:0]} + dec_offset;
        r.index_second = {4'h0, b[7:4]} + dec_offset;
        r.pair_count   = pairs;
        take           = {pairs, 1'b0};
        if ({15'd0, take} >= dec_pixels_left)
            dec_pixels_left = '0;
        else
            dec_pixels_left = dec_pixels_left - {15'd0, take};
        if (dec_pixels_left == '0)
        begin
            r.frame_done = 1'b1;
            dec_phase    = PH_WAIT;
            dec_run_left = '0;
        end
        return r;
    endfunction

    // Advance the decoder model by one stream byte; returns 1 when a result is due.
    function automatic bit decode_byte(input logic [7:0] b, input logic fs,
                                       output nrsd_result_t r);
        logic [23:0] owed;
        logic [6:0]  pairs;
        bit          produced;
        r        = '0;
        produced = 1'b0;
        if (fs)
        begin
            // A frame start restarts the header whatever the phase.
            dec_width       = {7'd0, b};
            dec_run_left    = '0;
            dec_pixels_left = '0;
            dec_phase       = PH_HDR1;
        end
        else
        begin
            case (dec_phase)
                PH_HDR1:
                begin
                    dec_width      = {b[6:0], dec_width[7:0]};
                    dec_compressed = b[7];
                    dec_phase      = PH_HDR2;
                end
                PH_HDR2:
                begin
                    dec_height      = b;
                    dec_pixels_left = {8'd0, dec_width} * {15'd0, b};
                    dec_phase       = PH_HDR3;
                end
                PH_HDR3:
                begin
                    dec_offset     = b;
                    r.frame_width  = dec_width;
                    r.frame_height = dec_height;
                    if (dec_pixels_left == '0)
                    begin
                        r.status     = STAT_EMPTY;
                        r.frame_done = 1'b1;
                        dec_phase    = PH_WAIT;
                    end
                    else if (!dec_compressed)
                    begin
                        r.status        = STAT_UNCOMPRESSED;
                        r.frame_done    = 1'b1;
                        dec_pixels_left = '0;
                        dec_phase       = PH_WAIT;
                    end
                    else
                    begin
                        r.status  = STAT_HEADER;
                        dec_phase = PH_CTRL;
                    end
                    produced = 1'b1;
                end
                PH_CTRL:
                begin
                    dec_run_left = b[6:0];
                    if (b[7])
                        dec_phase = PH_REP;
                    else if (b[6:0] != 7'd0)
                        dec_phase = PH_LIT;
                end
                PH_REP:
                begin
                    dec_phase = PH_CTRL;
                    // A repeat count of zero swallows its data byte.
                    if (dec_run_left != 7'd0)
                    begin
                        owed  = ({1'b0, dec_pixels_left} + 24'd1) >> 1;
                        pairs = ({17'd0, dec_run_left} < owed) ? dec_run_left : owed[6:0];
                        dec_run_left = '0;
                        r        = emit_run(b, pairs);
                        produced = 1'b1;
                    end
                end
                PH_LIT:
                begin
                    if (dec_run_left != 7'd0)
                        dec_run_left = dec_run_left - 7'd1;
                    if (dec_run_left == 7'd0)
                        dec_phase = PH_CTRL;
                    r        = emit_run(b, 7'd1);
                    produced = 1'b1;
                end
                default:
                begin
                    // Stray bytes between frames are dropped.
                    dec_phase = PH_WAIT;
                end
            endcase
        end
        return produced;
    endfunction

    // Length of an idle stretch: mostly short, now and then long.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 3);
        return $urandom_range(6, 24);
    endfunction

    // Count for a control byte: zero sometimes, mostly small, a few up to the maximum.
    function automatic int pick_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 0;
        if (r < 80)
            return $urandom_range(1, 8);
        if (r < 95)
            return $urandom_range(9, 40);
        return $urandom_range(41, 127);
    endfunction

    // Result side: random back-pressure.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result_if.ready <= 1'b0;
            stall_left      <= 0;
        end
        else if (stall_left > 0)
        begin
            result_if.ready <= 1'b0;
            stall_left      <= stall_left - 1;
        end
        else
        begin
            result_if.ready <= 1'b1;
            if (stalls_on && $urandom_range(0, 99) < 20)
                stall_left <= idle_len();
        end
    end

    // Check result transactions, then feed accepted stream bytes to the model.
    always @(posedge clk)
    begin
        nrsd_result_t got;
        nrsd_result_t want;
        nrsd_result_t due;
        if (rst_n)
        begin
            if (result_if.valid && result_if.ready)
            begin
                got = {result_if.status, result_if.frame_width, result_if.frame_height,
                       result_if.index_first, result_if.index_second,
                       result_if.pair_count, result_if.frame_done};
                results_seen++;
                if (got.status == STAT_RUN)
                    runs_seen++;
                if (expected_results.size() == 0)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("Unexpected result: status=%0d width=%0d height=%0d",
                                 got.status, got.frame_width, got.frame_height);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.status !== want.status || got.frame_width !== want.frame_width ||
                        got.frame_height !== want.frame_height ||
                        got.index_first !== want.index_first ||
                        got.index_second !== want.index_second ||
                        got.pair_count !== want.pair_count ||
                        got.frame_done !== want.frame_done)
                    begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                        begin
                            $display("Mismatch on result %0d:", results_seen);
                            $display("  expected status=%0d w=%0d h=%0d idx=%0d/%0d n=%0d done=%0d",
                                     want.status, want.frame_width, want.frame_height,
                                     want.index_first, want.index_second, want.pair_count,
                                     want.frame_done);
                            $display("  actual   status=%0d w=%0d h=%0d idx=%0d/%0d n=%0d done=%0d",
                                     got.status, got.frame_width, got.frame_height,
                                     got.index_first, got.index_second, got.pair_count,
                                     got.frame_done);
                        end
                    end
                end
            end
            if (stream_if.valid && stream_if.ready)
            begin
                if (decode_byte(stream_if.data_byte, stream_if.frame_start, due))
                    expected_results.push_back(due);
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long.
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((stream_if.valid && stream_if.ready) || (result_if.valid && result_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Timeout: no transaction for %0d cycles.", STALL_LIMIT);
        $display("tb failed");
        $finish;
    end

    // Send one stream byte and wait until the decoder takes it.
    task automatic send_byte(input logic [7:0] b, input logic fs);
        int gap;
        gap = 0;
        if (gaps_on && $urandom_range(0, 99) < 30)
            gap = idle_len();
        if (gap > 0)
        begin
            stream_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        stream_if.valid       <= 1'b1;
        stream_if.data_byte   <= b;
        stream_if.frame_start <= fs;
        @(posedge clk);
        while (!stream_if.ready)
            @(posedge clk);
        bytes_sent++;
        if (fs)
            frames_sent++;
    endtask

    // Send the four header bytes of a frame.
    task automatic send_header(input logic [14:0] w, input logic comp, input logic [7:0] h,
                               input logic [7:0] off);
        send_byte(w[7:0], 1'b1);
        send_byte({comp, w[14:8]}, 1'b0);
        send_byte(h, 1'b0);
        send_byte(off, 1'b0);
    endtask

    // A stray byte between frames, then a header broken off for the next frame start to restart.
    task automatic test_stray_and_restart();
        send_byte(8'hFF, 1'b0);
        send_byte(8'h10, 1'b1);
        send_byte(8'h81, 1'b0);
    endtask

    // Header extremes: an empty frame of full width and a full-size uncompressed frame.
    task automatic test_header_cases();
        send_header(15'h7FFF, 1'b1, 8'h00, 8'h7F);
        send_header(15'h7FFF, 1'b0, 8'hFF, 8'h80);
    endtask

    // A 5x3 compressed frame with a negative offset: zero counts, literals,
    // a repeat, and a repeat cut short at the odd pixel total.
    task automatic test_compressed_runs();
        send_header(15'd5, 1'b1, 8'd3, 8'hF8);
        send_byte(8'h00, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'h02, 1'b0);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h3C, 1'b0);
        send_byte(8'h83, 1'b0);
        send_byte(8'hF0, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h0F, 1'b0);
    endtask

    // Random control bytes and data for a compressed frame, up to max_ctrl runs.
    task automatic send_compressed_body(input int unsigned total, input int max_ctrl);
        int unsigned left;
        int          n_ctrl;
        int          count;
        int          i;
        left   = total;
        n_ctrl = 0;
        while (left > 0 && n_ctrl < max_ctrl)
        begin
            n_ctrl++;
            count = pick_count();
            if ($urandom_range(0, 1))
            begin
                send_byte(8'h80 | 8'(count), 1'b0);
                send_byte(8'($urandom), 1'b0);
                left = (2 * count >= left) ? 0 : left - 2 * count;
            end
            else
            begin
                send_byte(8'(count), 1'b0);
                for (i = 0; i < count && left > 0; i++)
                begin
                    send_byte(8'($urandom), 1'b0);
                    left = (left <= 2) ? 0 : left - 2;
                end
            end
        end
    endtask

    // Random frames: mostly well-formed compressed ones, plus the odd cases and noise.
    task automatic test_random_frames();
        logic [14:0] w;
        logic [7:0]  h;
        int          kind;
        int          n;
        int          i;
        while (bytes_sent - noise_bytes < TARGET_BYTES)
        begin
            gaps_on   = ($urandom_range(0, 3) != 0);
            stalls_on = ($urandom_range(0, 3) != 0);
            kind      = $urandom_range(0, 99);
            if (kind < 70)
            begin
                w = 15'($urandom_range(1, 24));
                h = 8'($urandom_range(1, 6));
                send_header(w, 1'b1, h, 8'($urandom));
                // Now and then cut the frame short; the next frame start restarts it.
                n = ($urandom_range(0, 99) < 5) ? $urandom_range(1, 4) : 1000;
                send_compressed_body(w * h, n);
            end
            else if (kind < 76)
            begin
                // Large frame, abandoned after a few runs.
                w = 15'($urandom);
                h = 8'($urandom_range(1, 255));
                if (w == 15'd0)
                    w = 15'd1;
                send_header(w, 1'b1, h, 8'($urandom));
                send_compressed_body(w * h, $urandom_range(1, 10));
            end
            else if (kind < 82)
            begin
                send_header(15'($urandom), 1'b0, 8'($urandom_range(1, 255)), 8'($urandom));
                n = $urandom_range(0, 3);
                for (i = 0; i < n; i++)
                    send_byte(8'($urandom), 1'b0);
                noise_bytes += n;
            end
            else if (kind < 88)
            begin
                if ($urandom_range(0, 1))
                    send_header(15'd0, 1'($urandom), 8'($urandom), 8'($urandom));
                else
                    send_header(15'($urandom), 1'($urandom), 8'd0, 8'($urandom));
            end
            else if (kind < 94)
            begin
                // Header broken off after one to three bytes.
                n = $urandom_range(1, 3);
                send_byte(8'($urandom), 1'b1);
                for (i = 1; i < n; i++)
                    send_byte(8'($urandom), 1'b0);
            end
            else
            begin
                n = $urandom_range(1, 4);
                for (i = 0; i < n; i++)
                    send_byte(8'($urandom), 1'b0);
                noise_bytes += n;
            end
        end
    endtask

    // Main sequence.
    initial
    begin
        clk                   = 1'b0;
        rst_n                 = 1'b0;
        stream_if.valid       = 1'b0;
        stream_if.data_byte   = '0;
        stream_if.frame_start = 1'b0;
        result_if.ready       = 1'b0;
        errors                = 0;
        results_seen          = 0;
        runs_seen             = 0;
        bytes_sent            = 0;
        noise_bytes           = 0;
        frames_sent           = 0;
        gaps_on               = 1'b1;
        stalls_on             = 1'b1;
        reset_decoder();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_stray_and_restart();
        test_header_cases();
        test_compressed_runs();
        test_random_frames();

        // Drain the remaining results, then allow for the pipeline latency.
        stream_if.valid <= 1'b0;
        stalls_on = 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (expected_results.size() != 0)
            errors++;
        $display("Sent %0d stream bytes over %0d frame starts, with gaps and back-pressure.",
                 bytes_sent, frames_sent);
        $display("Checked %0d results, %0d of them pixel runs; %0d errors.",
                 results_seen, runs_seen, errors);
        if (errors == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
